// File: hw/rtl/dsc_pkg.sv
// dsc_pkg: shared constants for the divisor sum classifier.
// Used by the top level and the port checker; depends on nothing.
`default_nettype none

package dsc_pkg;

  // default number width of the analyzed value
  localparam int VALUE_BITS_DEF = 20;

  // configuration register
  localparam int LIMIT_W     = 20;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 20'hFFFFF;

  // register file: byte address = 4 * index
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;
  localparam int REG_IDX_W  = 1;
  localparam logic [REG_IDX_W-1:0] REG_UPPER_LIMIT = 1'b0;

  // result word field widths and saturation points
  localparam int COUNT_W = 8;
  localparam int SUM_W   = 22;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;
  localparam logic [SUM_W-1:0]   SUM_MAX   = 22'h3FFFFF;

endpackage

`default_nettype wire

// File: hw/rtl/dsc_div.sv
// dsc_div: restoring divider, one quotient bit per cycle.
// Shared by every trial division of the classifier; uses no package items.
`default_nettype none

module dsc_div #(
  parameter int N_W = 20,
  parameter int D_W = 11
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire logic [N_W-1:0] dividend,
  input  wire logic [D_W-1:0] divisor,
  output logic                done,
  output logic [N_W-1:0]      quotient,
  output logic                rem_zero
);

  localparam int STEP_W = $clog2(N_W);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [D_W-1:0]    dvs;
  logic [D_W-1:0]    rem;
  logic [N_W-1:0]    quo;

  // one trial subtract per cycle
  logic [D_W:0] trial;
  logic [D_W:0] diff;
  logic         fits;

  assign trial = {rem, quo[N_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign fits  = trial >= {1'b0, dvs};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= STEP_W'(N_W - 1);
      end else if (busy) begin
        step <= step - 1'b1;
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: quotient bits shift in as dividend bits shift out
  always_ff @(posedge clk) begin
    if (start) begin
      dvs <= divisor;
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      rem <= fits ? diff[D_W-1:0] : trial[D_W-1:0];
      quo <= {quo[N_W-2:0], fits};
    end
  end

  assign quotient = quo;
  assign rem_zero = (rem == '0);

endmodule

`default_nettype wire

// File: hw/rtl/divisor_sum_classifier.sv
// Work: one aliquot pass, plus a partner pass when the sum exceeds the value and is at most
// upper_limit; each pass tries divisors d with d * d <= n on the shared bit-serial divider,
// with one extra step per divisor pair. Values below 2 go straight to the result. One word
// at a time: input stall is high from accept to result load.
// The result register holds one finished word, so a new word is taken while it waits.
// Reset (rst, synchronous): sequencer idle, no result pending, upper_limit = 1048575.
`default_nettype none

module divisor_sum_classifier #(
  parameter int VALUE_BITS = dsc_pkg::VALUE_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // input words
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [VALUE_BITS-1:0]           value,
  // result words
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [dsc_pkg::COUNT_W-1:0]          divisor_count,
  output logic [dsc_pkg::SUM_W-1:0]            divisor_sum,
  output logic                                 is_perfect,
  output logic                                 is_amicable_smaller,
  // configuration
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [dsc_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [dsc_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [dsc_pkg::APB_DATA_W-1:0]       prdata,
  output logic                                 pready
);

  // working number: the value, or a partner sum bounded by the limit
  localparam int N_W   = (VALUE_BITS > dsc_pkg::LIMIT_W) ? VALUE_BITS : dsc_pkg::LIMIT_W;
  localparam int D_W   = (N_W + 1) / 2 + 1;
  localparam int SQ_W  = N_W + 1;
  localparam int ACC_W = N_W + 3;
  localparam int CNT_W = D_W + 1;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CHECK = 6'b000010,
    S_DIV   = 6'b000100,
    S_ADDQ  = 6'b001000,
    S_END   = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state;

  logic [dsc_pkg::LIMIT_W-1:0] upper_limit;
  logic [VALUE_BITS-1:0]       v;
  logic [N_W-1:0]              n;
  logic [D_W-1:0]              d;
  logic [SQ_W-1:0]             sq;
  logic [ACC_W-1:0]            s;
  logic [CNT_W-1:0]            c;
  logic                        pass;

  logic [dsc_pkg::COUNT_W-1:0] res_count;
  logic [dsc_pkg::SUM_W-1:0]   res_sum;
  logic                        res_perfect;
  logic                        res_amic;

  logic           div_start;
  logic           div_done;
  logic [N_W-1:0] div_q;
  logic           div_rem_zero;

  logic in_take;
  logic out_take;
  logic out_load;
  logic cfg_wr;
  logic [dsc_pkg::REG_IDX_W-1:0] reg_idx;

  logic [ACC_W-1:0] v_ext;
  logic [ACC_W-1:0] lim_ext;
  logic             q_is_d;

  assign in_stall  = (state != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_take  = out_valid && !out_stall;
  assign out_load  = (state == S_DONE) && (!out_valid || !out_stall);
  assign div_start = (state == S_CHECK) && (sq <= SQ_W'(n));

  assign v_ext   = ACC_W'(v);
  assign lim_ext = ACC_W'(upper_limit);
  assign q_is_d  = (div_q == N_W'(d));

  // shared trial divider
  dsc_div #(
    .N_W (N_W),
    .D_W (D_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (n),
    .divisor  (d),
    .done     (div_done),
    .quotient (div_q),
    .rem_zero (div_rem_zero)
  );

  // configuration port, word-aligned decode
  assign pready  = 1'b1;
  assign reg_idx = paddr[dsc_pkg::APB_ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    unique case (reg_idx)
      dsc_pkg::REG_UPPER_LIMIT: prdata = dsc_pkg::APB_DATA_W'(upper_limit);
      default:                  prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upper_limit <= dsc_pkg::LIMIT_RESET;
    end else if (cfg_wr && reg_idx == dsc_pkg::REG_UPPER_LIMIT) begin
      upper_limit <= pwdata[dsc_pkg::LIMIT_W-1:0];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pass  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_take) begin
            pass  <= 1'b0;
            state <= (value < VALUE_BITS'(2)) ? S_DONE : S_CHECK;
          end
        end
        S_CHECK: state <= div_start ? S_DIV : S_END;
        S_DIV: begin
          if (div_done) begin
            state <= (div_rem_zero && !q_is_d) ? S_ADDQ : S_CHECK;
          end
        end
        S_ADDQ: state <= S_CHECK;
        S_END: begin
          if (!pass && s > v_ext && s <= lim_ext) begin
            pass  <= 1'b1;
            state <= S_CHECK;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // trial loop datapath: count, sum, divisor and its square
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_take) begin
          v           <= value;
          n           <= N_W'(value);
          c           <= CNT_W'(1);
          s           <= ACC_W'(1);
          d           <= D_W'(2);
          sq          <= SQ_W'(4);
          res_count   <= '0;
          res_sum     <= '0;
          res_perfect <= 1'b0;
          res_amic    <= 1'b0;
        end
      end
      S_DIV: begin
        if (div_done) begin
          if (div_rem_zero) begin
            c <= c + 1'b1;
            s <= s + ACC_W'(d);
          end
          if (!div_rem_zero || q_is_d) begin
            d  <= d + 1'b1;
            sq <= sq + SQ_W'({d, 1'b1});
          end
        end
      end
      S_ADDQ: begin
        c  <= c + 1'b1;
        s  <= s + ACC_W'(div_q);
        d  <= d + 1'b1;
        sq <= sq + SQ_W'({d, 1'b1});
      end
      S_END: begin
        if (!pass) begin
          res_count   <= (c > CNT_W'(dsc_pkg::COUNT_MAX)) ? dsc_pkg::COUNT_MAX
                                                          : c[dsc_pkg::COUNT_W-1:0];
          res_sum     <= (s > ACC_W'(dsc_pkg::SUM_MAX)) ? dsc_pkg::SUM_MAX
                                                        : s[dsc_pkg::SUM_W-1:0];
          res_perfect <= (s == v_ext);
          // partner pass: the sum is at most the limit, so it fits n
          n  <= N_W'(s);
          c  <= CNT_W'(1);
          s  <= ACC_W'(1);
          d  <= D_W'(2);
          sq <= SQ_W'(4);
        end else begin
          res_amic <= (s == v_ext);
        end
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      divisor_count       <= res_count;
      divisor_sum         <= res_sum;
      is_perfect          <= res_perfect;
      is_amicable_smaller <= res_amic;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/dsc_chk.sv
// dsc_chk: port-level checks on the divisor sum classifier, bound to the top level.
// Depends on dsc_pkg for port widths.
`default_nettype none

module dsc_chk (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            in_valid,
  input wire logic                            in_stall,
  input wire logic                            out_valid,
  input wire logic                            out_stall,
  input wire logic [dsc_pkg::COUNT_W-1:0]     divisor_count,
  input wire logic [dsc_pkg::SUM_W-1:0]       divisor_sum,
  input wire logic                            is_perfect,
  input wire logic                            is_amicable_smaller
);

  // reset leaves the block ready with nothing pending
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

  // one word at a time: busy right after taking a word
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again while busy");

  // a perfect number cannot be the smaller member of an amicable pair
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(is_perfect && is_amicable_smaller))
    else $error("perfect and amicable both flagged");

  // no divisors means value below two: empty result
  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && divisor_count == '0 |->
      divisor_sum == '0 && !is_perfect && !is_amicable_smaller)
    else $error("nonzero result with zero divisor count");

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(divisor_count) &&
      $stable(divisor_sum) && $stable(is_perfect) && $stable(is_amicable_smaller))
    else $error("stalled result word changed");

endmodule

bind divisor_sum_classifier dsc_chk u_dsc_chk (.*);

`default_nettype wire
